// ===== design/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, phase codes and opcode constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_BINARY = 3'd1;
    localparam logic [2:0] KIND_PING   = 3'd2;
    localparam logic [2:0] KIND_PONG   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;

    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [7:0] LEN7_MASK   = 8'h7F;
    localparam logic [7:0] MASK_FLAG   = 8'h80;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;

    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_LEN7   = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_KEY    = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       known;
        logic [2:0] kind;
    } t_kind_info;

    typedef struct packed {
        logic       valid;
        logic [2:0] frame_kind;
        logic [7:0] payload_byte;
        logic       data_present;
        logic       frame_end;
    } t_result;

    function automatic t_kind_info opcode_kind(input logic [3:0] op);
        t_kind_info info;
        info.known = 1'b1;
        unique case (op)
            OP_TEXT:   info.kind = KIND_TEXT;
            OP_BINARY: info.kind = KIND_BINARY;
            OP_PING:   info.kind = KIND_PING;
            OP_PONG:   info.kind = KIND_PONG;
            OP_CLOSE:  info.kind = KIND_CLOSE;
            default: begin
                info.known = 1'b0;
                info.kind  = KIND_TEXT;
            end
        endcase
        return info;
    endfunction

endpackage

`default_nettype wire

// ===== design/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header parse state and, for each accepted byte, computes the next
// state and the optional result word in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser #(
    parameter int LEN_BITS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_rx_byte,
    output wsd_pkg::t_result     o_result
);

    wsd_pkg::t_phase      r_phase, n_phase;
    logic [3:0]           r_opcode, n_opcode;
    logic                 r_mask_on, n_mask_on;
    logic [LEN_BITS-1:0]  r_remaining, n_remaining;
    logic [2:0]           r_hdr_count, n_hdr_count;
    logic [31:0]          r_mask_key, n_mask_key;
    logic [1:0]           r_mask_lane, n_mask_lane;

    wsd_pkg::t_kind_info  kind_info;
    logic [6:0]           len7;
    logic [LEN_BITS-1:0]  len_shifted;
    logic                 last_data;
    logic [7:0]           key_byte;
    logic [7:0]           data_byte;

    assign kind_info   = wsd_pkg::opcode_kind(r_opcode);
    assign len7        = 7'(i_rx_byte & wsd_pkg::LEN7_MASK);
    assign len_shifted = {r_remaining[LEN_BITS-9:0], i_rx_byte};
    assign last_data   = (r_remaining[LEN_BITS-1:1] == '0);
    assign key_byte    = 8'(r_mask_key >> {3'(2'd3 - r_mask_lane), 3'd0});
    assign data_byte   = r_mask_on ? (i_rx_byte ^ key_byte) : i_rx_byte;

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask_on   = r_mask_on;
        n_remaining = r_remaining;
        n_hdr_count = r_hdr_count;
        n_mask_key  = r_mask_key;
        n_mask_lane = r_mask_lane;
        unique case (r_phase)
            wsd_pkg::PH_LEN7: begin
                n_mask_on   = (i_rx_byte & wsd_pkg::MASK_FLAG) != 8'h00;
                n_remaining = '0;
                n_hdr_count = 3'd0;
                if (len7 == wsd_pkg::LEN7_EXT16) begin
                    n_phase = wsd_pkg::PH_EXT16;
                end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                    n_phase = wsd_pkg::PH_EXT64;
                end else begin
                    n_remaining = LEN_BITS'(len7);
                    if (n_mask_on) begin
                        n_phase    = wsd_pkg::PH_KEY;
                        n_mask_key = '0;
                    end else begin
                        n_mask_lane = 2'd0;
                        n_phase = (len7 == 7'd0) ? wsd_pkg::PH_OPCODE : wsd_pkg::PH_DATA;
                    end
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                n_remaining = len_shifted;
                if (r_hdr_count >= ((r_phase == wsd_pkg::PH_EXT16) ?
                                    wsd_pkg::EXT16_LAST : wsd_pkg::EXT64_LAST)) begin
                    n_hdr_count = 3'd0;
                    if (r_mask_on) begin
                        n_phase    = wsd_pkg::PH_KEY;
                        n_mask_key = '0;
                    end else begin
                        n_mask_lane = 2'd0;
                        n_phase = (len_shifted == '0) ? wsd_pkg::PH_OPCODE
                                                      : wsd_pkg::PH_DATA;
                    end
                end else begin
                    n_hdr_count = r_hdr_count + 3'd1;
                end
            end
            wsd_pkg::PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], i_rx_byte};
                if (r_hdr_count >= wsd_pkg::KEY_LAST) begin
                    n_hdr_count = 3'd0;
                    n_mask_lane = 2'd0;
                    n_phase = (r_remaining == '0) ? wsd_pkg::PH_OPCODE : wsd_pkg::PH_DATA;
                end else begin
                    n_hdr_count = r_hdr_count + 3'd1;
                end
            end
            wsd_pkg::PH_DATA: begin
                n_mask_lane = r_mask_lane + 2'd1;
                if (last_data) begin
                    n_remaining = '0;
                    n_phase     = wsd_pkg::PH_OPCODE;
                end else begin
                    n_remaining = r_remaining - LEN_BITS'(1);
                end
            end
            default: begin
                n_opcode = 4'(i_rx_byte & wsd_pkg::OPCODE_MASK);
                n_phase  = wsd_pkg::PH_LEN7;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        unique case (r_phase)
            wsd_pkg::PH_LEN7: begin
                if ((i_rx_byte & wsd_pkg::MASK_FLAG) == 8'h00 && len7 == 7'd0) begin
                    o_result.valid = kind_info.known;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
                if (r_hdr_count >= ((r_phase == wsd_pkg::PH_EXT16) ?
                                    wsd_pkg::EXT16_LAST : wsd_pkg::EXT64_LAST) &&
                    !r_mask_on && len_shifted == '0) begin
                    o_result.valid = kind_info.known;
                end
            end
            wsd_pkg::PH_KEY: begin
                if (r_hdr_count >= wsd_pkg::KEY_LAST && r_remaining == '0) begin
                    o_result.valid = kind_info.known;
                end
            end
            wsd_pkg::PH_DATA: begin
                if (kind_info.kind == wsd_pkg::KIND_PONG) begin
                    o_result.valid = kind_info.known && last_data;
                end else begin
                    o_result.valid        = kind_info.known;
                    o_result.payload_byte = data_byte;
                    o_result.data_present = 1'b1;
                end
                o_result.frame_end = last_data;
            end
            default: begin
                o_result.valid = 1'b0;
            end
        endcase
        if (r_phase != wsd_pkg::PH_DATA) begin
            o_result.frame_end = 1'b1;
        end
        o_result.frame_kind = kind_info.kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsd_pkg::PH_OPCODE;
            r_opcode    <= '0;
            r_mask_on   <= 1'b0;
            r_remaining <= '0;
            r_hdr_count <= '0;
            r_mask_key  <= '0;
            r_mask_lane <= '0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_mask_on   <= n_mask_on;
            r_remaining <= n_remaining;
            r_hdr_count <= n_hdr_count;
            r_mask_key  <= n_mask_key;
            r_mask_lane <= n_mask_lane;
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsd_pkg::PH_DATA |-> r_remaining != '0)
        else $error("data phase entered with no bytes remaining");

    a_key_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsd_pkg::PH_KEY |-> r_mask_on)
        else $error("mask key phase without mask flag");

    a_ext16_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wsd_pkg::PH_EXT16 |-> r_hdr_count <= wsd_pkg::EXT16_LAST)
        else $error("16-bit length overran its byte count");

endmodule

`default_nettype wire

// ===== design/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses a received WebSocket byte stream and emits unmasked payload words.
// ----------------------------------------------------------------------------
// The input channel (i_valid, i_rx_byte, o_stall) takes one stream byte per
// word. The output channel (o_valid, payload fields, i_stall) delivers zero
// or one word per input byte: a payload byte with its frame kind, or an end
// marker for pong and empty frames. The last word of each frame has
// o_frame_end set. Frames with unknown opcodes produce no output.
// Each byte is parsed in the cycle it is accepted and its word is registered
// into the output queue. One byte can be accepted every cycle while o_stall
// is low; the parser's single-pass header and unmask logic sets the rate.
// A two-word output queue lets the core take a byte while a finished word
// waits; o_stall rises only when both queue entries are occupied.
// Reset returns the parser to the start of a frame and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_core #(
    parameter int LEN_BITS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_frame_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_data_present,
    output logic            o_frame_end
);

    wsd_pkg::t_result result;
    wsd_pkg::t_result r_head;
    wsd_pkg::t_result r_skid;
    logic             r_head_valid;
    logic             r_skid_valid;
    logic             take;
    logic             push;
    logic             pop;

    assign o_stall = r_skid_valid;
    assign take    = i_valid && !r_skid_valid;
    assign push    = take && result.valid;
    assign pop     = r_head_valid && !i_stall;

    wsd_parser #(
        .LEN_BITS(LEN_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                if (push) begin
                    r_skid <= result;
                end else begin
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                r_head <= result;
            end else begin
                r_head_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_head_valid) begin
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end else begin
                r_head       <= result;
                r_head_valid <= 1'b1;
            end
        end
    end

    assign o_valid        = r_head_valid;
    assign o_frame_kind   = r_head.frame_kind;
    assign o_payload_byte = r_head.payload_byte;
    assign o_data_present = r_head.data_present;
    assign o_frame_end    = r_head.frame_end;

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry occupied while head is empty");

    a_stalled_push_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && r_head_valid && i_stall |=> r_skid_valid)
        else $error("word pushed behind a stalled head was lost");

    a_pop_skid_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_skid_valid |=> r_head_valid)
        else $error("skid word dropped when head was taken");

endmodule

`default_nettype wire
